@@ sv/dpt_pkg.sv @@
// Shared types and codes for the demand paging translator.
// No dependencies; the top level refers to it by scoped names.
`timescale 1ns / 1ps

package dpt_pkg;

  // Command codes on the cmd port
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_CLEAR     = 1'b1;

  // Replacement policy register codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_LOADED    = 3'd1;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd2;
  localparam logic [2:0] ST_NO_VICTIM = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

  // Sequencer states, one-hot
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CLEAR = 10'b00_0000_0010,
    S_LOOK  = 10'b00_0000_0100,
    S_FPOP  = 10'b00_0000_1000,
    S_FWAIT = 10'b00_0001_0000,
    S_FVAL  = 10'b00_0010_0000,
    S_SCAN  = 10'b00_0100_0000,
    S_SCANF = 10'b00_1000_0000,
    S_EVICT = 10'b01_0000_0000,
    S_LOAD  = 10'b10_0000_0000
  } state_t;

endpackage

@@ sv/demand_paging_translator.sv @@
// Demand paging address translator with FIFO or LRU page replacement.
// Uses dpt_pkg for state type, command, policy and status codes.
`timescale 1ns / 1ps

//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+---------------------------
//  command   | cmd, vaddr                                     | taken when start && !busy
//  result    | paddr, status, evicted,                        | valid for one cycle on done
//            | evicted_page, hit_count, fault_count           |
//  config    | replace_policy                                 | written when cfg_we
//
// A bad address is answered from idle, a hit from the lookup, a miss with a free frame
// goes straight to the load; an LRU miss scans every page entry (one page entry compared
// per cycle in the scan), a FIFO miss pops queue entries and drops stale ones until it
// finds a resident page or the queue runs empty, and clear walks every page entry.
// Reset runs a clearing pass over every entry of the page memory with
// busy high and no result. The receiver cannot stall; done is a one-cycle strobe.

module demand_paging_translator #(
  parameter int PAGE_COUNT  = 64,
  parameter int FRAME_COUNT = 16,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        replace_policy,
  input  logic        start,
  input  logic        cmd,
  input  logic [31:0] vaddr,
  output logic        busy,
  output logic        done,
  output logic [15:0] paddr,
  output logic [2:0]  status,
  output logic        evicted,
  output logic [5:0]  evicted_page,
  output logic [31:0] hit_count,
  output logic [31:0] fault_count
);

  localparam int OB = $clog2(PAGE_BYTES);
  localparam int VW = 32 - OB;
  localparam int PW = $clog2(PAGE_COUNT);
  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int UW = $clog2(FRAME_COUNT + 1);
  localparam int MW = 33 + FW;

  localparam logic [VW-1:0] PAGE_LIM   = VW'(PAGE_COUNT);
  localparam logic [PW-1:0] PAGE_LAST  = PW'(PAGE_COUNT - 1);
  localparam logic [FW-1:0] FRAME_LAST = FW'(FRAME_COUNT - 1);
  localparam logic [UW-1:0] FRAME_NUM  = UW'(FRAME_COUNT);

  // Page table memory: {valid, frame, stamp}
  logic [MW-1:0] page_mem [PAGE_COUNT];
  logic [MW-1:0] rd_q;
  logic          mem_we;
  logic [PW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;
  logic [PW-1:0] mem_ra;

  // FIFO queue memory of resident pages
  logic [PW-1:0] fifo_mem [FRAME_COUNT];
  logic [PW-1:0] fifo_rd;
  logic          fifo_we;
  logic [FW-1:0] fifo_wa;

  dpt_pkg::state_t state;
  logic          quiet;
  logic          policy;
  logic [PW-1:0] clr_idx;
  logic [PW-1:0] page_q;
  logic [OB-1:0] offset_q;
  logic [FW-1:0] frame_sel;
  logic [PW-1:0] victim;
  logic          evict_flag;
  logic [31:0]   time_now;
  logic [31:0]   hits_total;
  logic [31:0]   faults_total;
  logic [UW-1:0] used_frames;
  logic [FW-1:0] fifo_head;
  logic [UW-1:0] fifo_count;

  // LRU scan registers
  logic [PW-1:0] scan_idx;
  logic [PW-1:0] pend_idx;
  logic          scan_pend;
  logic          best_found;
  logic [PW-1:0] best_idx;
  logic [31:0]   best_stamp;
  logic [FW-1:0] best_frame;

  logic          rd_valid;
  logic [FW-1:0] rd_frame;
  logic [31:0]   rd_stamp;
  logic          scan_take;
  logic [31:0]   time_next;
  logic [FW-1:0] head_inc;
  logic          fifo_full;
  logic [FW-1:0] push_head;
  logic [UW-1:0] push_cnt;
  logic [FW:0]   tail_sum;

  assign rd_valid = rd_q[MW-1];
  assign rd_frame = rd_q[MW-2:32];
  assign rd_stamp = rd_q[31:0];

  assign busy        = (state != dpt_pkg::S_IDLE);
  assign hit_count   = hits_total;
  assign fault_count = faults_total;

  // Shared compare: one page entry against the best so far
  assign scan_take = scan_pend && rd_valid && (!best_found || (rd_stamp < best_stamp));

  // Saturating time advance
  assign time_next = (time_now == 32'hFFFF_FFFF) ? time_now : time_now + 32'd1;

  // Queue pointer arithmetic; a full queue drops its oldest word on push
  assign head_inc  = (fifo_head == FRAME_LAST) ? '0 : fifo_head + 1'b1;
  assign fifo_full = (fifo_count >= FRAME_NUM);
  assign push_head = fifo_full ? head_inc : fifo_head;
  assign push_cnt  = fifo_full ? FRAME_NUM - 1'b1 : fifo_count;
  assign tail_sum  = (FW + 1)'(push_head) + (FW + 1)'(push_cnt);
  assign fifo_wa   = (tail_sum >= (FW + 1)'(FRAME_COUNT)) ?
                     FW'(tail_sum - (FW + 1)'(FRAME_COUNT)) : FW'(tail_sum);
  assign fifo_we   = (state == dpt_pkg::S_LOAD) && (policy == dpt_pkg::POLICY_FIFO);

  // Page memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = page_q;
    mem_wd = '0;
    mem_ra = page_q;
    case (state)
      dpt_pkg::S_IDLE:  mem_ra = vaddr[OB+PW-1:OB];
      dpt_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx;
      end
      dpt_pkg::S_LOOK: begin
        if (rd_valid && (policy == dpt_pkg::POLICY_LRU)) begin
          mem_we = 1'b1;
          mem_wd = {1'b1, rd_frame, time_now};
        end
      end
      dpt_pkg::S_FWAIT: mem_ra = fifo_rd;
      dpt_pkg::S_SCAN:  mem_ra = scan_idx;
      dpt_pkg::S_EVICT: begin
        mem_we = 1'b1;
        mem_wa = victim;
      end
      dpt_pkg::S_LOAD: begin
        mem_we = 1'b1;
        mem_wd = {1'b1, frame_sel, time_now};
      end
      default: mem_ra = page_q;
    endcase
  end

  // Page memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem[mem_wa] <= mem_wd;
    end
    rd_q <= page_mem[mem_ra];
  end

  // Queue memory, read at the head when popping
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_wa] <= page_q;
    end
    if (state == dpt_pkg::S_FPOP) begin
      fifo_rd <= fifo_mem[fifo_head];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dpt_pkg::S_CLEAR;
      clr_idx      <= '0;
      quiet        <= 1'b1;
      done         <= 1'b0;
      policy       <= dpt_pkg::POLICY_FIFO;
      hits_total   <= '0;
      faults_total <= '0;
      time_now     <= '0;
      used_frames  <= '0;
      fifo_head    <= '0;
      fifo_count   <= '0;
      scan_pend    <= 1'b0;
      best_found   <= 1'b0;
      evict_flag   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        policy <= replace_policy;
      end
      case (state)
        dpt_pkg::S_IDLE: begin
          if (start) begin
            page_q     <= vaddr[OB+PW-1:OB];
            offset_q   <= vaddr[OB-1:0];
            evict_flag <= 1'b0;
            if (cmd == dpt_pkg::CMD_CLEAR) begin
              hits_total   <= '0;
              faults_total <= '0;
              time_now     <= '0;
              used_frames  <= '0;
              fifo_head    <= '0;
              fifo_count   <= '0;
              clr_idx      <= '0;
              quiet        <= 1'b0;
              state        <= dpt_pkg::S_CLEAR;
            end else if (vaddr[31:OB] >= PAGE_LIM) begin
              paddr        <= '0;
              status       <= dpt_pkg::ST_BAD_ADDR;
              evicted      <= 1'b0;
              evicted_page <= '0;
              done         <= 1'b1;
            end else begin
              state <= dpt_pkg::S_LOOK;
            end
          end
        end

        // One page entry cleared per cycle
        dpt_pkg::S_CLEAR: begin
          if (clr_idx == PAGE_LAST) begin
            state <= dpt_pkg::S_IDLE;
            if (!quiet) begin
              paddr        <= '0;
              status       <= dpt_pkg::ST_CLEARED;
              evicted      <= 1'b0;
              evicted_page <= '0;
              done         <= 1'b1;
            end
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end

        // Table lookup result
        dpt_pkg::S_LOOK: begin
          if (rd_valid) begin
            if (hits_total != 32'hFFFF_FFFF) begin
              hits_total <= hits_total + 32'd1;
            end
            if (policy == dpt_pkg::POLICY_LRU) begin
              time_now <= time_next;
            end
            paddr        <= 16'({rd_frame, offset_q});
            status       <= dpt_pkg::ST_HIT;
            evicted      <= 1'b0;
            evicted_page <= '0;
            done         <= 1'b1;
            state        <= dpt_pkg::S_IDLE;
          end else begin
            if (faults_total != 32'hFFFF_FFFF) begin
              faults_total <= faults_total + 32'd1;
            end
            if (used_frames < FRAME_NUM) begin
              // frames are handed out in order and only freed by a clear or a reset
              frame_sel   <= used_frames[FW-1:0];
              used_frames <= used_frames + 1'b1;
              state       <= dpt_pkg::S_LOAD;
            end else if (policy == dpt_pkg::POLICY_LRU) begin
              scan_idx   <= '0;
              scan_pend  <= 1'b0;
              best_found <= 1'b0;
              state      <= dpt_pkg::S_SCAN;
            end else begin
              state <= dpt_pkg::S_FPOP;
            end
          end
        end

        // Pop the oldest queued page
        dpt_pkg::S_FPOP: begin
          if (fifo_count == '0) begin
            paddr        <= '0;
            status       <= dpt_pkg::ST_NO_VICTIM;
            evicted      <= 1'b0;
            evicted_page <= '0;
            done         <= 1'b1;
            state        <= dpt_pkg::S_IDLE;
          end else begin
            fifo_head  <= head_inc;
            fifo_count <= fifo_count - 1'b1;
            state      <= dpt_pkg::S_FWAIT;
          end
        end

        dpt_pkg::S_FWAIT: state <= dpt_pkg::S_FVAL;

        // Stale queue words are dropped
        dpt_pkg::S_FVAL: begin
          if (rd_valid) begin
            victim    <= fifo_rd;
            frame_sel <= rd_frame;
            state     <= dpt_pkg::S_EVICT;
          end else begin
            state <= dpt_pkg::S_FPOP;
          end
        end

        // LRU scan: issue one read per cycle, compare the previous one
        dpt_pkg::S_SCAN: begin
          scan_pend <= 1'b1;
          pend_idx  <= scan_idx;
          if (scan_take) begin
            best_found <= 1'b1;
            best_idx   <= pend_idx;
            best_stamp <= rd_stamp;
            best_frame <= rd_frame;
          end
          if (scan_idx == PAGE_LAST) begin
            state <= dpt_pkg::S_SCANF;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end

        dpt_pkg::S_SCANF: begin
          scan_pend <= 1'b0;
          if (scan_take || best_found) begin
            victim    <= scan_take ? pend_idx : best_idx;
            frame_sel <= scan_take ? rd_frame : best_frame;
            state     <= dpt_pkg::S_EVICT;
          end else begin
            paddr        <= '0;
            status       <= dpt_pkg::ST_NO_VICTIM;
            evicted      <= 1'b0;
            evicted_page <= '0;
            done         <= 1'b1;
            state        <= dpt_pkg::S_IDLE;
          end
        end

        dpt_pkg::S_EVICT: begin
          evict_flag <= 1'b1;
          state      <= dpt_pkg::S_LOAD;
        end

        // Install the page, stamp it, queue it under FIFO
        dpt_pkg::S_LOAD: begin
          time_now <= time_next;
          if (fifo_we) begin
            fifo_head  <= push_head;
            fifo_count <= push_cnt + 1'b1;
          end
          paddr        <= 16'({frame_sel, offset_q});
          status       <= dpt_pkg::ST_LOADED;
          evicted      <= evict_flag;
          evicted_page <= evict_flag ? 6'(victim) : 6'd0;
          done         <= 1'b1;
          state        <= dpt_pkg::S_IDLE;
        end

        default: state <= dpt_pkg::S_IDLE;
      endcase
    end
  end

endmodule
